@@ rtl/wsht_pkg.sv @@
// ----------------------------------------------------------------------------
// wsht_pkg
// Shared types and constants for the window stack hit test block.
// ----------------------------------------------------------------------------
`default_nettype none

package wsht_pkg;

  // default sizes
  localparam int DEF_MAX_WINDOWS = 16;
  localparam int DEF_COORD_BITS  = 12;

  // fixed port field widths
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 4;
  localparam int CRD_W  = 12;

  // input opcodes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CLICK = 1'b1;

  // click sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PICK
  } state_t;

  // broadcast control to every cell
  typedef struct packed {
    logic load;    // write rectangle of the matching window
    logic cmp;     // latch the point test
    logic commit;  // apply the raise-to-top reorder
    logic found;   // some cell in use holds the point
  } cell_ctrl_t;

  // per-cell status back to the top
  typedef struct packed {
    logic sel;       // this cell is the topmost hit
    logic load_hit;  // this cell matches the load window number
  } cell_stat_t;

endpackage : wsht_pkg

`default_nettype wire

@@ rtl/wsht_cell.sv @@
// ----------------------------------------------------------------------------
// wsht_cell
// One stack position: window number, its rectangle and the latched point test.
// ----------------------------------------------------------------------------
`default_nettype none

module wsht_cell #(
  parameter int MAX_WINDOWS = wsht_pkg::DEF_MAX_WINDOWS,
  parameter int COORD_BITS  = wsht_pkg::DEF_COORD_BITS,
  parameter int POS         = 0
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire wsht_pkg::cell_ctrl_t          ctrl,
  input  wire [$clog2(MAX_WINDOWS+1)-1:0]    n_eff,
  input  wire [$clog2(MAX_WINDOWS)-1:0]      load_id,
  input  wire [4*COORD_BITS-1:0]             load_rect,
  input  wire [COORD_BITS-1:0]               px,
  input  wire [COORD_BITS-1:0]               py,
  input  wire [$clog2(MAX_WINDOWS)-1:0]      up_id,
  input  wire [4*COORD_BITS-1:0]             up_rect,
  input  wire [$clog2(MAX_WINDOWS)-1:0]      carry_in_id,
  input  wire [4*COORD_BITS-1:0]             carry_in_rect,
  input  wire                                above_in,
  output logic [$clog2(MAX_WINDOWS)-1:0]     id_out,
  output logic [4*COORD_BITS-1:0]            rect_out,
  output logic [$clog2(MAX_WINDOWS)-1:0]     carry_out_id,
  output logic [4*COORD_BITS-1:0]            carry_out_rect,
  output logic                               above_out,
  output wsht_pkg::cell_stat_t               stat
);

  localparam int IDW = $clog2(MAX_WINDOWS);
  localparam int NW  = $clog2(MAX_WINDOWS+1);
  localparam int CB  = COORD_BITS;
  localparam logic [NW-1:0] POS_V = NW'(POS);
  localparam logic [NW-1:0] TOP_V = NW'(POS + 1);

  logic [IDW-1:0]  id_r, id_nxt;
  logic [4*CB-1:0] rect_r, rect_nxt;
  logic            hit_r, hit_nxt;
  logic            in_use, is_top, sel, inside_w;
  logic [CB-1:0]   lx, by, rx, ty;

  // position in use and top-of-stack decode
  assign in_use = (n_eff > POS_V);
  assign is_top = (n_eff == TOP_V);

  assign lx = rect_r[4*CB-1:3*CB];
  assign by = rect_r[3*CB-1:2*CB];
  assign rx = rect_r[2*CB-1:CB];
  assign ty = rect_r[CB-1:0];

  // inclusive point-in-rectangle test
  assign inside_w = (px >= lx) && (px <= rx) && (py >= by) && (py <= ty);

  // topmost hit: nothing hit above this cell
  assign sel       = hit_r & ~above_in;
  assign above_out = hit_r | above_in;

  // selected entry rides the carry chain up to the top
  assign carry_out_id   = sel ? id_r : carry_in_id;
  assign carry_out_rect = sel ? rect_r : carry_in_rect;

  assign id_out   = id_r;
  assign rect_out = rect_r;

  assign stat.sel      = sel;
  assign stat.load_hit = ctrl.load && (id_r == load_id);

  // next state of the cell
  always_comb begin
    id_nxt   = id_r;
    rect_nxt = rect_r;
    hit_nxt  = hit_r;
    if (ctrl.cmp) begin
      hit_nxt = in_use && inside_w;
    end
    if (stat.load_hit) begin
      rect_nxt = load_rect;
    end
    if (ctrl.commit && ctrl.found) begin
      if (is_top) begin
        if (!sel) begin
          id_nxt   = carry_in_id;
          rect_nxt = carry_in_rect;
        end
      end else if (in_use && !above_in) begin
        id_nxt   = up_id;
        rect_nxt = up_rect;
      end
    end
  end

  // stack order and hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r  <= IDW'(POS);
      hit_r <= 1'b0;
    end else begin
      id_r  <= id_nxt;
      hit_r <= hit_nxt;
    end
  end

  // rectangle storage, undefined until loaded
  always_ff @(posedge clk) begin
    rect_r <= rect_nxt;
  end

endmodule : wsht_cell

`default_nettype wire

@@ rtl/window_stack_hit_test_core.sv @@
// ----------------------------------------------------------------------------
// window_stack_hit_test_core
// Z-ordered rectangle hit test with raise to top over a row of stack cells.
// ----------------------------------------------------------------------------
// A load transaction (func 0) writes one window's inclusive corners and returns
// nothing; the block is ready again the next cycle. A click transaction
// (func 1) latches the point, tests it against every cell of the stack row
// in the next cycle, then picks the topmost hit, raises it to the top and
// writes the result register; the next transaction is taken only after the
// result register is written. The pick cycle waits while the output register
// still holds an untaken result. The user must write window_count through
// cfg_wr_en only while the block is idle; the block itself does not enforce it.
`default_nettype none

module window_stack_hit_test_core #(
  parameter int MAX_WINDOWS = wsht_pkg::DEF_MAX_WINDOWS,
  parameter int COORD_BITS  = wsht_pkg::DEF_COORD_BITS
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // configuration
  input  wire                         cfg_wr_en,
  input  wire [wsht_pkg::CNT_W-1:0]   cfg_window_count,
  // input channel
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_func,
  input  wire [wsht_pkg::IDX_W-1:0]   in_window_index,
  input  wire [wsht_pkg::CRD_W-1:0]   in_left_x,
  input  wire [wsht_pkg::CRD_W-1:0]   in_bottom_y,
  input  wire [wsht_pkg::CRD_W-1:0]   in_right_x,
  input  wire [wsht_pkg::CRD_W-1:0]   in_top_y,
  // result channel
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_hit,
  output logic [wsht_pkg::IDX_W-1:0]  out_window_id
);

  localparam int IDW  = $clog2(MAX_WINDOWS);
  localparam int NW   = $clog2(MAX_WINDOWS+1);
  localparam int CB   = COORD_BITS;
  localparam int CMPW = (NW > wsht_pkg::CNT_W) ? NW : wsht_pkg::CNT_W;

  wsht_pkg::state_t     state_r, state_nxt;
  wsht_pkg::cell_ctrl_t ctrl;

  logic [NW-1:0]   n_eff_r, n_eff_nxt;
  logic [CB-1:0]   px_r, py_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_hit_r;
  logic [wsht_pkg::IDX_W-1:0] out_window_id_r;

  logic            accept, commit, found;
  logic [CMPW-1:0] cfg_ext;
  logic [31:0]     idx_w, crd_lx, crd_by, crd_rx, crd_ty, sel_id_w;
  logic [IDW-1:0]  load_id;
  logic [4*CB-1:0] load_rect;
  logic            idx_ok;

  // cell row interconnect
  logic [IDW-1:0]  id_w       [MAX_WINDOWS+1];
  logic [4*CB-1:0] rect_w     [MAX_WINDOWS+1];
  logic [IDW-1:0]  carry_id   [MAX_WINDOWS+1];
  logic [4*CB-1:0] carry_rect [MAX_WINDOWS+1];
  logic [MAX_WINDOWS:0]       above_w;
  logic [MAX_WINDOWS-1:0]     sel_v, load_hit_v;
  wsht_pkg::cell_stat_t       stat_w [MAX_WINDOWS];

  assign accept = in_valid && in_ready;

  // field extraction to internal widths
  assign idx_w     = 32'(in_window_index);
  assign load_id   = idx_w[IDW-1:0];
  assign idx_ok    = (int'(in_window_index) < MAX_WINDOWS);
  assign crd_lx    = 32'(in_left_x);
  assign crd_by    = 32'(in_bottom_y);
  assign crd_rx    = 32'(in_right_x);
  assign crd_ty    = 32'(in_top_y);
  assign load_rect = {crd_lx[CB-1:0], crd_by[CB-1:0], crd_rx[CB-1:0], crd_ty[CB-1:0]};

  // window count clamp
  assign cfg_ext   = CMPW'(cfg_window_count);
  assign n_eff_nxt = cfg_wr_en ?
                     ((cfg_ext > CMPW'(MAX_WINDOWS)) ? NW'(MAX_WINDOWS) : NW'(cfg_ext)) :
                     n_eff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r <= NW'(1);
    end else begin
      n_eff_r <= n_eff_nxt;
    end
  end

  // click point latch
  always_ff @(posedge clk) begin
    if (accept && (in_func == wsht_pkg::FUNC_CLICK)) begin
      px_r <= crd_lx[CB-1:0];
      py_r <= crd_by[CB-1:0];
    end
  end

  // sequencer next state and cell control
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    commit      = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.cmp    = 1'b0;
    ctrl.commit = 1'b0;
    ctrl.found  = found;
    case (state_r)
      wsht_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == wsht_pkg::FUNC_CLICK) begin
            state_nxt = wsht_pkg::ST_CMP;
          end else begin
            ctrl.load = idx_ok;
          end
        end
      end
      wsht_pkg::ST_CMP: begin
        ctrl.cmp  = 1'b1;
        state_nxt = wsht_pkg::ST_PICK;
      end
      wsht_pkg::ST_PICK: begin
        if (!out_valid_r || out_ready) begin
          commit      = 1'b1;
          ctrl.commit = 1'b1;
          state_nxt   = wsht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wsht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsht_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // chain ends
  assign id_w[MAX_WINDOWS]   = '0;
  assign rect_w[MAX_WINDOWS] = '0;
  assign carry_id[0]         = '0;
  assign carry_rect[0]       = '0;
  assign above_w[MAX_WINDOWS] = 1'b0;
  assign found               = above_w[0];

  // row of stack cells, position 0 at the bottom
  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    wsht_cell #(
      .MAX_WINDOWS (MAX_WINDOWS),
      .COORD_BITS  (COORD_BITS),
      .POS         (i)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .n_eff          (n_eff_r),
      .load_id        (load_id),
      .load_rect      (load_rect),
      .px             (px_r),
      .py             (py_r),
      .up_id          (id_w[i+1]),
      .up_rect        (rect_w[i+1]),
      .carry_in_id    (carry_id[i]),
      .carry_in_rect  (carry_rect[i]),
      .above_in       (above_w[i+1]),
      .id_out         (id_w[i]),
      .rect_out       (rect_w[i]),
      .carry_out_id   (carry_id[i+1]),
      .carry_out_rect (carry_rect[i+1]),
      .above_out      (above_w[i]),
      .stat           (stat_w[i])
    );
    assign sel_v[i]      = stat_w[i].sel;
    assign load_hit_v[i] = stat_w[i].load_hit;
  end

  // result register
  assign sel_id_w      = 32'(carry_id[MAX_WINDOWS]);
  assign out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r       <= found;
      out_window_id_r <= found ? sel_id_w[wsht_pkg::IDX_W-1:0] : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_window_id = out_window_id_r;

  // window numbers stay unique, so a load touches at most one cell
  a_load_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(load_hit_v))
    else $error("load matched more than one stack cell");

  // at most one topmost hit is picked
  a_sel_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wsht_pkg::ST_PICK) |-> $onehot0(sel_v))
    else $error("more than one cell selected");

  // a click always goes to the compare cycle
  a_click_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == wsht_pkg::FUNC_CLICK)) |=> (state_r == wsht_pkg::ST_CMP))
    else $error("click did not enter compare");

  // a load never raises a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == wsht_pkg::FUNC_LOAD) && !out_valid_r) |=> !out_valid_r)
    else $error("load produced a result");

  // a miss reports window zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_window_id_r == '0))
    else $error("miss with nonzero window id");

endmodule : window_stack_hit_test_core

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the window stack hit test core. Loads window
// rectangles, clicks points under several window counts and compares each
// hit result with a local z-order model updated on every accepted transaction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CNT_W        = wsht_pkg::CNT_W;
  localparam int IDX_W        = wsht_pkg::IDX_W;
  localparam int CRD_W        = wsht_pkg::CRD_W;
  localparam int NUM_WIN      = wsht_pkg::DEF_MAX_WINDOWS;
  localparam int CRD_MAX      = (1 << CRD_W) - 1;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] id;
  } hit_result_t;

  typedef struct packed {
    logic [CRD_W-1:0] lx;
    logic [CRD_W-1:0] by;
    logic [CRD_W-1:0] rx;
    logic [CRD_W-1:0] ty;
  } rect_t;

  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             cfg_wr_en        = 1'b0;
  logic [CNT_W-1:0] cfg_window_count = '0;
  logic             in_valid         = 1'b0;
  logic             in_func          = wsht_pkg::FUNC_LOAD;
  logic [IDX_W-1:0] in_window_index  = '0;
  logic [CRD_W-1:0] in_left_x        = '0;
  logic [CRD_W-1:0] in_bottom_y      = '0;
  logic [CRD_W-1:0] in_right_x       = '0;
  logic [CRD_W-1:0] in_top_y         = '0;
  logic             out_ready        = 1'b0;
  wire              in_ready;
  wire              out_valid;
  wire              out_hit;
  wire  [IDX_W-1:0] out_window_id;

  // model of the window store and the stacking order
  rect_t            win_rect [NUM_WIN];
  logic [IDX_W-1:0] z_order  [NUM_WIN];
  logic [CNT_W-1:0] live_count;
  hit_result_t      pending_hits [$];
  int               mismatches  = 0;
  int               idle_cycles = 0;
  bit               quiet_mode  = 1'b0;

  window_stack_hit_test_core #(
    .MAX_WINDOWS (NUM_WIN),
    .COORD_BITS  (wsht_pkg::DEF_COORD_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_window_count (cfg_window_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_window_index  (in_window_index),
    .in_left_x        (in_left_x),
    .in_bottom_y      (in_bottom_y),
    .in_right_x       (in_right_x),
    .in_top_y         (in_top_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_window_id    (out_window_id)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= quiet_mode || ($urandom_range(0, 99) >= 33);
  end

  // topmost window holding the point, raised to the top of the live stack
  function automatic hit_result_t hit_and_raise(logic [CRD_W-1:0] px,
                                                logic [CRD_W-1:0] py);
    hit_result_t      res;
    int               n;
    logic [IDX_W-1:0] w;
    res = '0;
    n = (live_count > NUM_WIN) ? NUM_WIN : live_count;
    for (int pos = n - 1; pos >= 0; pos--) begin
      w = z_order[pos];
      if (!res.hit && px >= win_rect[w].lx && px <= win_rect[w].rx &&
          py >= win_rect[w].by && py <= win_rect[w].ty) begin
        res.hit = 1'b1;
        res.id  = w;
        for (int k = pos; k < n - 1; k++) z_order[k] = z_order[k + 1];
        z_order[n - 1] = w;
      end
    end
    return res;
  endfunction

  task automatic flag_error(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // track every transaction, check each result, watch for a hang
  always @(posedge clk) begin
    hit_result_t due;
    if (!rst_n) begin
      for (int i = 0; i < NUM_WIN; i++) begin
        win_rect[i] = '0;
        z_order[i]  = IDX_W'(i);
      end
      live_count = CNT_W'(1);
      pending_hits.delete();
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_wr_en) begin
        live_count  = cfg_window_count;
        idle_cycles = 0;
      end
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        if (in_func == wsht_pkg::FUNC_LOAD) begin
          win_rect[in_window_index] = '{in_left_x, in_bottom_y, in_right_x, in_top_y};
        end else begin
          pending_hits.push_back(hit_and_raise(in_left_x, in_bottom_y));
        end
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (pending_hits.size() == 0) begin
          flag_error($sformatf("result hit=%0b id=%0d with nothing pending",
                               out_hit, out_window_id));
        end else begin
          due = pending_hits.pop_front();
          if (out_hit !== due.hit || out_window_id !== due.id)
            flag_error($sformatf("expected hit=%0b id=%0d, got hit=%0b id=%0d",
                                 due.hit, due.id, out_hit, out_window_id));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // drive one transaction and hold it until accepted, then maybe idle
  task automatic send_item(logic func, logic [IDX_W-1:0] idx,
                           logic [CRD_W-1:0] ax, logic [CRD_W-1:0] ay,
                           logic [CRD_W-1:0] bx, logic [CRD_W-1:0] bt);
    in_func         <= func;
    in_window_index <= idx;
    in_left_x       <= ax;
    in_bottom_y     <= ay;
    in_right_x      <= bx;
    in_top_y        <= bt;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!quiet_mode && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_window(logic [IDX_W-1:0] idx, rect_t r);
    send_item(wsht_pkg::FUNC_LOAD, idx, r.lx, r.by, r.rx, r.ty);
  endtask

  task automatic click_at(logic [CRD_W-1:0] px, logic [CRD_W-1:0] py);
    send_item(wsht_pkg::FUNC_CLICK, IDX_W'($urandom), px, py,
              CRD_W'($urandom), CRD_W'($urandom));
  endtask

  // let the block drain, then change the window count
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_window_count(logic [CNT_W-1:0] cnt);
    wait_drained();
    cfg_window_count <= cnt;
    cfg_wr_en        <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly proper rectangles, some inverted
  function automatic rect_t random_rect();
    rect_t r;
    int    span_x;
    int    span_y;
    logic [CRD_W-1:0] tmp;
    r.lx   = CRD_W'($urandom_range(0, CRD_MAX));
    r.by   = CRD_W'($urandom_range(0, CRD_MAX));
    span_x = $urandom_range(0, 1600);
    span_y = $urandom_range(0, 1600);
    r.rx   = (r.lx + span_x > CRD_MAX) ? CRD_W'(CRD_MAX) : CRD_W'(r.lx + span_x);
    r.ty   = (r.by + span_y > CRD_MAX) ? CRD_W'(CRD_MAX) : CRD_W'(r.by + span_y);
    if ($urandom_range(0, 9) == 0) begin
      tmp  = r.lx;
      r.lx = r.rx;
      r.rx = tmp;
    end
    return r;
  endfunction

  // click aimed at some window: inside, on a corner, just past an edge or anywhere
  task automatic random_click();
    rect_t            r;
    logic [CRD_W-1:0] px;
    logic [CRD_W-1:0] py;
    r = win_rect[$urandom_range(0, NUM_WIN - 1)];
    if ($urandom_range(0, 4) == 0 || r.lx > r.rx || r.by > r.ty) begin
      px = CRD_W'($urandom);
      py = CRD_W'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          px = r.lx;
          py = r.by;
        end
        1: begin
          px = r.rx;
          py = r.ty;
        end
        2: begin
          px = r.rx + 1'b1;
          py = r.ty;
        end
        default: begin
          px = CRD_W'($urandom_range(r.rx, r.lx));
          py = CRD_W'($urandom_range(r.ty, r.by));
        end
      endcase
    end
    click_at(px, py);
  endtask

  // every window gets a rectangle before any click
  task automatic test_initial_loads();
    load_window(IDX_W'(0), '{12'd0, 12'd0, 12'hFFF, 12'hFFF});
    load_window(IDX_W'(1), '{12'd100, 12'd100, 12'd200, 12'd200});
    load_window(IDX_W'(2), '{12'd150, 12'd150, 12'd300, 12'd300});
    load_window(IDX_W'(3), '{12'd500, 12'd500, 12'd400, 12'd600});
    load_window(IDX_W'(4), '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    load_window(IDX_W'(5), '{12'd0, 12'd0, 12'd0, 12'd0});
    for (int i = 6; i < NUM_WIN; i++) load_window(IDX_W'(i), random_rect());
  endtask

  // inclusive bounds, overlap, inverted area, corner points
  task automatic test_edge_clicks();
    set_window_count(CNT_W'(NUM_WIN));
    click_at(12'd150, 12'd150);
    click_at(12'd100, 12'd100);
    click_at(12'd200, 12'd200);
    click_at(12'd201, 12'd199);
    click_at(12'd450, 12'd550);
    click_at(12'hFFF, 12'hFFF);
    click_at(12'd0, 12'd0);
  endtask

  // single window, empty stack, count above the stack size
  task automatic test_count_extremes();
    set_window_count(CNT_W'(1));
    click_at(12'd150, 12'd150);
    set_window_count('0);
    click_at(12'd0, 12'd0);
    set_window_count('1);
    click_at(12'hFFF, 12'hFFF);
    click_at(12'd300, 12'd300);
  endtask

  // phases of mixed loads and clicks under varying counts
  task automatic test_random_traffic();
    logic [CNT_W-1:0] counts [6];
    counts = '{5'd16, 5'($urandom_range(1, NUM_WIN)), 5'd2,
               5'($urandom_range(NUM_WIN + 1, 31)), 5'($urandom_range(1, NUM_WIN)),
               5'd16};
    foreach (counts[p]) begin
      set_window_count(counts[p]);
      quiet_mode = (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) load_window(IDX_W'($urandom), random_rect());
        else random_click();
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_initial_loads();
    test_edge_clicks();
    test_count_extremes();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
